FILE: hw/rtl/gbwe_pkg.sv
// ----------------------------------------------------------------------------
// gbwe_pkg
// Shared types and constants of the grid boundary wall extractor.
// ----------------------------------------------------------------------------
package gbwe_pkg;

  localparam int MaxHeight = 256;
  localparam int MaxWidth  = 256;

  localparam int CfgW     = 9;   // width of each size register
  localparam int CfgIdxW  = 1;   // two registers
  localparam int CoordW   = 9;   // width of a wall coordinate on the port

  localparam logic [CfgIdxW-1:0] RegGridWidth  = 1'b0;
  localparam logic [CfgIdxW-1:0] RegGridHeight = 1'b1;

  localparam logic OpCell  = 1'b0;
  localparam logic OpFlush = 1'b1;

  typedef enum logic [1:0] {
    SideNorth = 2'd0,
    SideSouth = 2'd1,
    SideWest  = 2'd2,
    SideEast  = 2'd3
  } side_e;

  typedef struct packed {
    logic opcode;
    logic occupied;
  } in_t;

  typedef struct packed {
    logic [CoordW-1:0] start_x;
    logic [CoordW-1:0] start_y;
    logic [CoordW-1:0] end_x;
    logic [CoordW-1:0] end_y;
    side_e             side;
    logic              last_of_cell;
  } out_t;

endpackage

FILE: hw/rtl/grid_boundary_wall_extractor.sv
// ----------------------------------------------------------------------------
// grid_boundary_wall_extractor
// Emits the unit wall segments around occupied cells of a column-major grid.
// ----------------------------------------------------------------------------
// Path: an item passes the stage-1 register and the column store read, then
//   the wall sequencer register, before its first wall shows on out_valid_o.
// Throughput: one item per cycle while items yield at most one wall and
//   out_ready_i is high; an item with more walls holds the input while they drain, set by the single result port.
// Reset: control state clears at once; the column store is not cleared and
//   needs no sweep, so in_ready_o is high straight out of reset.
// ----------------------------------------------------------------------------
module grid_boundary_wall_extractor
  import gbwe_pkg::*;
#(
  parameter int MAX_HEIGHT = MaxHeight,
  parameter int MAX_WIDTH  = MaxWidth
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // configuration writes
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_wdata_i,
  // cell and flush items
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  in_t                in_data_i,
  // wall segments
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output out_t               out_data_o
);

  // Widths derived from the grid limits
  localparam int YA  = $clog2(MAX_HEIGHT);      // row address into one column
  localparam int CXW = $clog2(MAX_WIDTH + 1);   // column coordinate, holds width
  localparam int CYW = $clog2(MAX_HEIGHT + 1);  // row coordinate, holds height
  localparam int EXW = (CXW > CfgW) ? CXW : CfgW;
  localparam int EYW = (CYW > CfgW) ? CYW : CfgW;

  // Item waiting for its column store reads
  typedef struct packed {
    logic [CXW-1:0] x;       // column being finished
    logic [CYW-1:0] y;       // row being finished
    logic           first;   // occupancy of (x,0)
    logic           s_edge;  // south neighbour off grid
    logic           e_edge;  // east neighbour off grid
    logic           east;    // east neighbour occupancy
  } fin_t;

  // --------------------------------------------------------------------------
  // Configuration registers and effective grid size
  // --------------------------------------------------------------------------
  logic [CfgW-1:0] cfg_w_q, cfg_h_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_w_q <= CfgW'(16);
      cfg_h_q <= CfgW'(16);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegGridWidth:  cfg_w_q <= cfg_wdata_i;
        RegGridHeight: cfg_h_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  logic [EXW-1:0] w_ext;
  logic [EYW-1:0] h_ext;
  logic [CXW-1:0] w_eff;
  logic [CYW-1:0] h_eff;

  // Clamp sizes: zero acts as one, oversize acts as the limit
  always_comb begin
    w_ext = EXW'(cfg_w_q);
    h_ext = EYW'(cfg_h_q);
    if (w_ext == '0) begin
      w_eff = CXW'(1);
    end else if (w_ext > EXW'(MAX_WIDTH)) begin
      w_eff = CXW'(MAX_WIDTH);
    end else begin
      w_eff = CXW'(w_ext);
    end
    if (h_ext == '0) begin
      h_eff = CYW'(1);
    end else if (h_ext > EYW'(MAX_HEIGHT)) begin
      h_eff = CYW'(MAX_HEIGHT);
    end else begin
      h_eff = CYW'(h_ext);
    end
  end

  // --------------------------------------------------------------------------
  // Traversal state (stage 0)
  // --------------------------------------------------------------------------
  logic [CXW-1:0] col_q, col_d;
  logic [CYW-1:0] row_q, row_d;
  logic [CYW-1:0] frow_q, frow_d;
  logic           await_q, await_d;
  logic           first_q, first_d;

  logic           in_acc;
  logic           fin_go;
  fin_t           fin;
  logic           wr_en;
  logic           wr_bank;
  logic [CXW-1:0] c_sel;
  logic [CYW-1:0] r_sel;
  logic [CYW-1:0] y_p1;

  logic           s1_valid_q;
  fin_t           s1_q;
  logic           s1_adv;
  logic           seq_free;

  assign in_ready_o = !s1_valid_q || seq_free;
  assign in_acc     = in_valid_i && in_ready_o;

  // A cell item out of range restarts the traversal at the origin
  assign c_sel = (col_q >= w_eff || row_q >= h_eff) ? '0 : col_q;
  assign r_sel = (col_q >= w_eff || row_q >= h_eff) ? '0 : row_q;

  always_comb begin
    col_d   = col_q;
    row_d   = row_q;
    frow_d  = frow_q;
    await_d = await_q;
    first_d = first_q;
    fin_go  = 1'b0;
    wr_en   = 1'b0;
    wr_bank = c_sel[0];
    fin     = '0;
    fin.first = first_q;

    if (cfg_we_i) begin
      // any register write restarts the traversal
      col_d   = '0;
      row_d   = '0;
      frow_d  = '0;
      await_d = 1'b0;
    end else if (in_acc) begin
      if (in_data_i.opcode == OpFlush) begin
        if (await_q) begin
          if (frow_q >= h_eff) begin
            col_d   = '0;
            row_d   = '0;
            frow_d  = '0;
            await_d = 1'b0;
          end else begin
            fin_go   = 1'b1;
            fin.x    = w_eff - CXW'(1);
            fin.y    = frow_q;
            fin.east = 1'b0;
            if (frow_q + CYW'(1) >= h_eff) begin
              col_d   = '0;
              row_d   = '0;
              frow_d  = '0;
              await_d = 1'b0;
            end else begin
              frow_d = frow_q + CYW'(1);
            end
          end
        end
      end else if (!await_q) begin
        // finish the cell to the west, store this one
        fin_go   = (c_sel != '0);
        fin.x    = c_sel - CXW'(1);
        fin.y    = r_sel;
        fin.east = in_data_i.occupied;
        wr_en    = 1'b1;
        if (r_sel == '0) begin
          first_d = in_data_i.occupied;
        end
        col_d = c_sel;
        if (r_sel + CYW'(1) >= h_eff) begin
          row_d = '0;
          if (c_sel + CXW'(1) >= w_eff) begin
            await_d = 1'b1;
            frow_d  = '0;
          end else begin
            col_d = c_sel + CXW'(1);
          end
        end else begin
          row_d = r_sel + CYW'(1);
        end
      end
    end
    fin.s_edge = (fin.y + CYW'(1) >= h_eff);
    fin.e_edge = (fin.x + CXW'(1) >= w_eff);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q   <= '0;
      row_q   <= '0;
      frow_q  <= '0;
      await_q <= 1'b0;
      first_q <= 1'b0;
    end else begin
      col_q   <= col_d;
      row_q   <= row_d;
      frow_q  <= frow_d;
      await_q <= await_d;
      first_q <= first_d;
    end
  end

  // --------------------------------------------------------------------------
  // Column store: even columns in bank 0, odd columns in bank 1.
  // The finished column's bank serves the south neighbour (row y+1); the
  // other bank serves the west neighbour (row y) and takes the new cell at
  // the same row in the same cycle, read-first, so the old column is seen.
  // --------------------------------------------------------------------------
  logic          ram_we    [2];
  logic [YA-1:0] ram_raddr [2];
  logic          ram_rdata [2];

  assign y_p1 = fin.y + CYW'(1);

  for (genvar b = 0; b < 2; b++) begin : g_bank
    assign ram_we[b]    = wr_en && (wr_bank == 1'(b));
    assign ram_raddr[b] = (fin.x[0] == 1'(b)) ? y_p1[YA-1:0] : fin.y[YA-1:0];

    gbwe_ram #(
      .Width (1),
      .Depth (MAX_HEIGHT)
    ) u_ram (
      .clk_i   (clk_i),
      .we_i    (ram_we[b]),
      .waddr_i (r_sel[YA-1:0]),
      .wdata_i (in_data_i.occupied),
      .re_i    (fin_go),
      .raddr_i (ram_raddr[b]),
      .rdata_o (ram_rdata[b])
    );
  end

  // --------------------------------------------------------------------------
  // Stage 1: read data back, build the wall mask
  // --------------------------------------------------------------------------
  logic       cen_q;     // center of the last finished cell (north of next)
  logic       sth_q;     // south read of the last finished cell (next center)
  logic       s1_cen, s1_sth, s1_west;
  logic [3:0] s1_mask;

  assign s1_adv = s1_valid_q && seq_free;

  always_comb begin
    s1_sth  = ram_rdata[s1_q.x[0]];
    s1_west = ram_rdata[~s1_q.x[0]];
    s1_cen  = (s1_q.y == '0) ? s1_q.first : sth_q;
    s1_mask = '0;
    if (s1_cen) begin
      s1_mask[SideNorth] = (s1_q.y == '0) || !cen_q;
      s1_mask[SideSouth] = s1_q.s_edge || !s1_sth;
      s1_mask[SideWest]  = (s1_q.x == '0) || !s1_west;
      s1_mask[SideEast]  = s1_q.e_edge || !s1_q.east;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (fin_go) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fin_go) begin
      s1_q <= fin;
    end
    if (s1_adv) begin
      cen_q <= s1_cen;
      sth_q <= s1_sth;
    end
  end

  // --------------------------------------------------------------------------
  // Wall sequencer: drain the mask one wall per output transaction
  // --------------------------------------------------------------------------
  logic [3:0]     seq_mask_q, seq_mask_d;
  logic [CXW-1:0] seq_x_q;
  logic [CYW-1:0] seq_y_q;
  logic [3:0]     low_bit;
  logic           seq_last;
  side_e          seq_side;
  logic [CXW-1:0] x_p1;
  logic [CYW-1:0] sy_p1;

  assign out_valid_o = (seq_mask_q != '0);
  assign low_bit     = seq_mask_q & (~seq_mask_q + 4'd1);
  assign seq_last    = ((seq_mask_q & ~low_bit) == '0);
  assign seq_free    = !out_valid_o || (out_ready_i && seq_last);

  always_comb begin
    if (seq_mask_q[SideNorth]) begin
      seq_side = SideNorth;
    end else if (seq_mask_q[SideSouth]) begin
      seq_side = SideSouth;
    end else if (seq_mask_q[SideWest]) begin
      seq_side = SideWest;
    end else begin
      seq_side = SideEast;
    end
  end

  always_comb begin
    seq_mask_d = seq_mask_q;
    if (s1_adv) begin
      seq_mask_d = s1_mask;
    end else if (out_valid_o && out_ready_i) begin
      seq_mask_d = seq_mask_q & ~low_bit;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_mask_q <= '0;
    end else begin
      seq_mask_q <= seq_mask_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      seq_x_q <= s1_q.x;
      seq_y_q <= s1_q.y;
    end
  end

  assign x_p1  = seq_x_q + CXW'(1);
  assign sy_p1 = seq_y_q + CYW'(1);

  // Corner coordinates of the current wall
  always_comb begin
    out_data_o.side         = seq_side;
    out_data_o.last_of_cell = seq_last;
    unique case (seq_side)
      SideSouth: begin
        out_data_o.start_x = CoordW'(seq_x_q);
        out_data_o.start_y = CoordW'(sy_p1);
        out_data_o.end_x   = CoordW'(x_p1);
        out_data_o.end_y   = CoordW'(sy_p1);
      end
      SideWest: begin
        out_data_o.start_x = CoordW'(seq_x_q);
        out_data_o.start_y = CoordW'(seq_y_q);
        out_data_o.end_x   = CoordW'(seq_x_q);
        out_data_o.end_y   = CoordW'(sy_p1);
      end
      SideEast: begin
        out_data_o.start_x = CoordW'(x_p1);
        out_data_o.start_y = CoordW'(seq_y_q);
        out_data_o.end_x   = CoordW'(x_p1);
        out_data_o.end_y   = CoordW'(sy_p1);
      end
      default: begin
        out_data_o.start_x = CoordW'(seq_x_q);
        out_data_o.start_y = CoordW'(seq_y_q);
        out_data_o.end_x   = CoordW'(x_p1);
        out_data_o.end_y   = CoordW'(seq_y_q);
      end
    endcase
  end

endmodule

FILE: hw/rtl/gbwe_ram.sv
// ----------------------------------------------------------------------------
// gbwe_ram
// Generic single-write, single-read RAM with registered read (read-first).
// ----------------------------------------------------------------------------
module gbwe_ram #(
  parameter int Width = 1,
  parameter int Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // hold old data on a same-address write
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hw/rtl/gbwe_checker.sv
// ----------------------------------------------------------------------------
// gbwe_checker
// Port-level checks of the grid boundary wall extractor, bound to the top.
// ----------------------------------------------------------------------------
module gbwe_checker
  import gbwe_pkg::*;
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input out_t               out_data_o
);

  // hold a stalled wall
  a_out_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("out_valid_o dropped before transaction");

  a_out_data_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(out_data_o))
    else $error("out_data_o changed while stalled");

  // walls of one cell follow each other in side order
  a_cell_walls_follow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !out_data_o.last_of_cell
    |=> out_valid_o && (out_data_o.side > $past(out_data_o.side)))
    else $error("wall sequence of a cell broken");

  // horizontal walls span one column, vertical walls one row
  a_unit_segment: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.side == SideNorth || out_data_o.side == SideSouth)
    |-> (out_data_o.end_x == out_data_o.start_x + 9'd1) &&
        (out_data_o.end_y == out_data_o.start_y))
    else $error("horizontal wall is not a unit segment");

  a_unit_segment_v: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.side == SideWest || out_data_o.side == SideEast)
    |-> (out_data_o.end_y == out_data_o.start_y + 9'd1) &&
        (out_data_o.end_x == out_data_o.start_x))
    else $error("vertical wall is not a unit segment");

endmodule

bind grid_boundary_wall_extractor gbwe_checker u_gbwe_checker (.*);

FILE: sim/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives cell and flush items into the grid boundary wall extractor, traces the
// same grid walk in a behavioral copy of the wall rules, and checks every wall
// segment that comes out against the oldest wall still due.
// ----------------------------------------------------------------------------
module testbench;
  import gbwe_pkg::*;

  localparam int RandomItems  = 125;   // counted items in the random part
  localparam int StallLimit   = 2000;  // cycles without any transaction
  localparam int SettleCycles = 8;     // lets the last item pass through the block, with margin

  // one pending input transaction; wait_drain holds it back until no wall is due
  typedef struct {
    in_t data;
    bit  wait_drain;
  } grid_item_t;

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               cfg_we_i    = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i   = RegGridWidth;
  logic [CfgW-1:0]    cfg_wdata_i = '0;
  logic               in_valid_i  = 1'b0;
  logic               in_ready_o;
  in_t                in_data_i   = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  out_t               out_data_o;

  grid_boundary_wall_extractor DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  always #1 clk_i = ~clk_i;

  // --------------------------------------------------------------------------
  // Grid walk tracker: its own copy of the size registers, the two-column
  // occupancy store and the traversal counters.
  // --------------------------------------------------------------------------
  grid_item_t      grid_items [$];   // items not yet presented to the block
  out_t            walls_due  [$];   // walls the block still owes, oldest first
  logic [CfgW-1:0] width_reg  = 9'd16;
  logic [CfgW-1:0] height_reg = 9'd16;
  bit              occ_store [2*MaxHeight];
  int unsigned     col_at     = 0;
  int unsigned     row_at     = 0;
  int unsigned     flush_at   = 0;
  bit              flushing   = 1'b0;

  int unsigned items_queued = 0;
  int unsigned items_taken  = 0;
  int unsigned random_items = 0;
  int unsigned fails        = 0;

  // a size of zero acts as one, anything above the maximum acts as the maximum
  function automatic int unsigned cols_eff();
    if (width_reg == 0) return 1;
    if (width_reg > MaxWidth) return MaxWidth;
    return width_reg;
  endfunction

  function automatic int unsigned rows_eff();
    if (height_reg == 0) return 1;
    if (height_reg > MaxHeight) return MaxHeight;
    return height_reg;
  endfunction

  // column x lives in half (x mod 2) of the store
  function automatic bit occ_at(int unsigned x, int unsigned y);
    return occ_store[(x % 2) * MaxHeight + y];
  endfunction

  function automatic out_t make_wall(int unsigned sx, int unsigned sy, int unsigned ex,
                                     int unsigned ey, side_e s);
    out_t w;
    w.start_x      = CoordW'(sx);
    w.start_y      = CoordW'(sy);
    w.end_x        = CoordW'(ex);
    w.end_y        = CoordW'(ey);
    w.side         = s;
    w.last_of_cell = 1'b0;
    return w;
  endfunction

  function automatic void restart_grid();
    col_at   = 0;
    row_at   = 0;
    flush_at = 0;
    flushing = 1'b0;
  endfunction

  // Queue the walls of cell (x,y) in north, south, west, east order. An empty
  // cell yields none; off-grid neighbours count as empty.
  function automatic void emit_cell_walls(int unsigned x, int unsigned y, bit east_occ);
    out_t segs [$];
    if (!occ_at(x, y)) return;
    if (y == 0 || !occ_at(x, y - 1))
      segs.insert(segs.size(), make_wall(x, y, x + 1, y, SideNorth));
    if (y + 1 >= rows_eff() || !occ_at(x, y + 1))
      segs.insert(segs.size(), make_wall(x, y + 1, x + 1, y + 1, SideSouth));
    if (x == 0 || !occ_at(x - 1, y))
      segs.insert(segs.size(), make_wall(x, y, x, y + 1, SideWest));
    if (x + 1 >= cols_eff() || !east_occ)
      segs.insert(segs.size(), make_wall(x + 1, y, x + 1, y + 1, SideEast));
    if (segs.size() == 0) return;
    segs[segs.size() - 1].last_of_cell = 1'b1;
    foreach (segs[i]) walls_due.insert(walls_due.size(), segs[i]);
  endfunction

  // Advance the walk by one accepted item.
  function automatic void step_grid(in_t item);
    int unsigned cols;
    int unsigned rows;
    cols = cols_eff();
    rows = rows_eff();
    if (item.opcode == OpFlush) begin
      // drop flushes outside the flush phase
      if (!flushing) return;
      if (flush_at >= rows) begin
        restart_grid();
        return;
      end
      emit_cell_walls(cols - 1, flush_at, 1'b0);
      flush_at++;
      if (flush_at >= rows) restart_grid();
      return;
    end
    // drop cells while the last column still waits for its flushes
    if (flushing) return;
    if (col_at >= cols || row_at >= rows) restart_grid();
    // a cell of column x finishes its west neighbour in column x-1
    if (col_at >= 1) emit_cell_walls(col_at - 1, row_at, item.occupied);
    occ_store[(col_at % 2) * MaxHeight + row_at] = item.occupied;
    row_at++;
    if (row_at >= rows) begin
      row_at = 0;
      if (col_at + 1 >= cols) begin
        flushing = 1'b1;
        flush_at = 0;
      end else begin
        col_at++;
      end
    end
  endfunction

  function automatic void check_field(string name, logic [CoordW-1:0] want,
                                      logic [CoordW-1:0] got);
    if (got !== want) begin
      fails++;
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
    end
  endfunction

  function automatic void check_wall(out_t got);
    out_t want;
    if (walls_due.size() == 0) begin
      fails++;
      $display("%0t: wall with none due, expected nothing actual %p", $time, got);
      return;
    end
    want = walls_due.pop_front();
    check_field("start_x", want.start_x, got.start_x);
    check_field("start_y", want.start_y, got.start_y);
    check_field("end_x", want.end_x, got.end_x);
    check_field("end_y", want.end_y, got.end_y);
    check_field("side", CoordW'(want.side), CoordW'(got.side));
    check_field("last_of_cell", CoordW'(want.last_of_cell), CoordW'(got.last_of_cell));
  endfunction

  // mostly short gaps, now and then a long one
  function automatic int unsigned idle_span();
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // --------------------------------------------------------------------------
  // Monitor: sample both handshakes at the rising edge. Check the result
  // before tracing a new item so a stray wall cannot match a fresh one.
  // --------------------------------------------------------------------------
  bit          in_taken     = 1'b0;
  bit          out_taken    = 1'b0;
  int unsigned quiet_cycles = 0;

  always @(posedge clk_i) begin
    in_taken  = rst_ni && in_valid_i && in_ready_o;
    out_taken = rst_ni && out_valid_o && out_ready_i;
    if (out_taken) check_wall(out_data_o);
    if (in_taken) begin
      step_grid(in_data_i);
      items_taken++;
    end
    // watchdog: end the run when the block stops moving
    if (!rst_ni || in_taken || out_taken) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= StallLimit) begin
        $display("%0t: no transaction for %0d cycles", $time, StallLimit);
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Driver: present items at the falling edge. Hold valid and payload until the
  // transaction goes through; alternate calm stretches with random gaps.
  // --------------------------------------------------------------------------
  int unsigned send_gap       = 0;
  bit          send_calm      = 1'b1;
  int unsigned send_calm_left = 30;

  always @(negedge clk_i) begin
    if (send_calm_left == 0) begin
      send_calm      = !send_calm;
      send_calm_left = $urandom_range(20, 120);
    end else begin
      send_calm_left--;
    end
    if (!rst_ni || (in_valid_i && !in_taken)) begin
      // hold the current transaction, or stay quiet during reset
    end else if (send_gap != 0) begin
      send_gap--;
      in_valid_i <= 1'b0;
    end else if (grid_items.size() != 0 &&
                 !(grid_items[0].wait_drain && walls_due.size() != 0)) begin
      in_data_i  <= grid_items[0].data;
      in_valid_i <= 1'b1;
      void'(grid_items.pop_front());
      if (!send_calm && $urandom_range(0, 99) < 35) send_gap = idle_span();
    end else begin
      in_valid_i <= 1'b0;
    end
  end

  // Result side: stall the block at random, with calm stretches in between.
  int unsigned take_stall     = 0;
  bit          take_calm      = 1'b0;
  int unsigned take_calm_left = 50;

  always @(negedge clk_i) begin
    if (take_calm_left == 0) begin
      take_calm      = !take_calm;
      take_calm_left = $urandom_range(20, 120);
    end else begin
      take_calm_left--;
    end
    if (take_stall != 0) begin
      take_stall--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
      if (!take_calm && $urandom_range(0, 99) < 25) take_stall = idle_span();
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  task automatic add_item(logic op, logic occ, bit drain);
    grid_item_t it;
    it.data.opcode   = op;
    it.data.occupied = occ;
    it.wait_drain    = drain || ($urandom_range(0, 49) == 0);
    grid_items.insert(grid_items.size(), it);
    items_queued++;
  endtask

  // Block until every item went through and every wall came back, then give
  // the block time to finish an item that owes no wall.
  task automatic settle();
    while (items_taken != items_queued || walls_due.size() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  // Any register write restarts the walk; mirror it in the tracker at once,
  // since nothing is in flight.
  task automatic write_size(logic [CfgIdxW-1:0] idx, logic [CfgW-1:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    if (idx == RegGridWidth) width_reg = val;
    else height_reg = val;
    restart_grid();
  endtask

  task automatic close_writes();
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // mostly tiny grids, sometimes zero or oversized values
  function automatic logic [CfgW-1:0] pick_size();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return CfgW'($urandom_range(1, 4));
    if (r < 70) return CfgW'($urandom_range(5, 8));
    if (r < 80) return '0;
    if (r < 90) return CfgW'($urandom_range(256, 511));
    return CfgW'($urandom_range(9, 255));
  endfunction

  task automatic reconfigure();
    case ($urandom_range(0, 3))
      0: begin
        write_size(RegGridWidth, pick_size());
        write_size(RegGridHeight, pick_size());
      end
      1: begin
        write_size(RegGridHeight, pick_size());
        write_size(RegGridWidth, pick_size());
      end
      2: write_size(RegGridWidth, pick_size());
      default: write_size(RegGridHeight, pick_size());
    endcase
    close_writes();
  endtask

  // Queue up to max_cells cells of the current grid in column-major order,
  // sprinkled with stray flushes. A complete grid gets its row flushes, with
  // stray cells between them and sometimes a surplus flush after them.
  task automatic queue_grid(int unsigned max_cells, int unsigned density);
    int unsigned cols;
    int unsigned rows;
    int unsigned sent;
    cols = cols_eff();
    rows = rows_eff();
    sent = 0;
    for (int unsigned x = 0; x < cols && sent < max_cells; x++) begin
      for (int unsigned y = 0; y < rows && sent < max_cells; y++) begin
        if ($urandom_range(0, 19) == 0) add_item(OpFlush, 1'($urandom_range(0, 1)), 1'b0);
        add_item(OpCell, $urandom_range(0, 99) < density, 1'b0);
        sent++;
      end
    end
    random_items += sent;
    if (sent < cols * rows) return;
    for (int unsigned y = 0; y < rows; y++) begin
      if ($urandom_range(0, 9) == 0) add_item(OpCell, 1'($urandom_range(0, 1)), 1'b0);
      add_item(OpFlush, 1'($urandom_range(0, 1)), 1'b0);
    end
    random_items += rows;
    if ($urandom_range(0, 4) == 0) add_item(OpFlush, 1'b1, 1'b0);
  endtask

  initial begin
    int unsigned cells;
    int unsigned limit;
    bit          grid_open;

    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;

    // flush straight after reset: nothing awaits it, drop
    add_item(OpFlush, 1'b0, 1'b0);
    settle();

    // full 3x3 grid: the center cell has four occupied neighbours and no walls
    write_size(RegGridWidth, 9'd3);
    write_size(RegGridHeight, 9'd3);
    close_writes();
    for (int i = 0; i < 9; i++) add_item(OpCell, 1'b1, 1'b0);
    // cell while flushes are due: dropped
    add_item(OpCell, 1'b0, 1'b0);
    // hold the first flush until every wall so far has drained
    for (int i = 0; i < 3; i++) add_item(OpFlush, i[0], i == 0);
    // surplus flush after the grid closed: dropped
    add_item(OpFlush, 1'b1, 1'b0);
    settle();

    // width zero acts as one: a single column finished only by flushes,
    // an occupied cell over an empty one
    write_size(RegGridWidth, 9'd0);
    write_size(RegGridHeight, 9'd2);
    close_writes();
    add_item(OpCell, 1'b1, 1'b0);
    add_item(OpCell, 1'b0, 1'b0);
    add_item(OpFlush, 1'b1, 1'b0);
    add_item(OpFlush, 1'b0, 1'b0);
    settle();

    // oversized height clamps to the maximum; leave this grid unfinished so
    // the next register write has to restart the walk
    write_size(RegGridHeight, 9'd511);
    write_size(RegGridWidth, 9'd2);
    close_writes();
    for (int i = 0; i < 3; i++) add_item(OpCell, 1'b1, 1'b0);
    grid_open    = 1'b1;
    random_items = 0;

    // random grids: mostly complete walks with random content, some cut short
    while (random_items < RandomItems) begin
      if (grid_open || $urandom_range(0, 2) == 0) begin
        settle();
        reconfigure();
      end
      cells = cols_eff() * rows_eff();
      if (cells <= 40 && $urandom_range(0, 99) < 85) limit = cells;
      else limit = $urandom_range(1, cells < 40 ? cells : 40);
      grid_open = limit < cells;
      queue_grid(limit, $urandom_range(0, 4) * 25);
    end

    // drain, then watch a little longer for stray walls
    settle();
    repeat (2 * SettleCycles) @(negedge clk_i);
    if (fails == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule
